FILE: sv/sacl_pkg.sv
// Shared types, constants and helper functions of the cache tag lookup unit.
package sacl_pkg;

   localparam int DEFAULT_WAYS = 4;
   localparam int DEFAULT_SETS = 64;

   localparam int TAG_W   = 32;
   localparam int AGE_W   = 32;
   localparam int LFSR_W  = 16;
   localparam int CSR_W   = 5;
   localparam int CSR_IDX_W = 2;

   localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
   localparam logic [AGE_W-1:0]  AGE_MAX   = 32'hFFFF_FFFF;

   // Access opcodes.
   localparam logic [1:0] OP_DATA_READ  = 2'd0;
   localparam logic [1:0] OP_DATA_WRITE = 2'd1;
   localparam logic [1:0] OP_INST_READ  = 2'd2;
   localparam logic [1:0] OP_LOOKUP     = 2'd3;

   // Replacement modes.
   localparam logic REPL_RANDOM = 1'b0;
   localparam logic REPL_LRU    = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_BITS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WRITE_ALLOC   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPL_MODE     = 2'd3;

   // One way of a set as it is kept in the tag memory.
   typedef struct packed {
      logic             valid;
      logic             dirty;
      logic [TAG_W-1:0] tag;
      logic [AGE_W-1:0] age;
   } way_type;

   localparam int WAY_BITS = $bits(way_type);

   // Outcome of one lookup, handed from the way logic to the control.
   typedef struct packed {
      logic             hit;
      logic             evicted;
      logic [TAG_W-1:0] evicted_tag;
      logic             evicted_dirty;
      logic             lfsr_step;
   } lookup_result_type;

   // Fibonacci LFSR with taps 16, 14, 13, 11, shifting right.
   function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] l);
      logic fb;
      fb = l[0] ^ l[2] ^ l[3] ^ l[5];
      return {fb, l[LFSR_W-1:1]};
   endfunction

endpackage

FILE: sv/sacl_if.sv
// Valid/ready channel interfaces for lookup requests and lookup responses.
interface sacl_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [31:0] address;

   modport source (output valid, output opcode, output address, input ready);
   modport sink   (input valid, input opcode, input address, output ready);
endinterface

interface sacl_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic        evicted;
   logic [31:0] evicted_tag;
   logic        evicted_dirty;
   logic [31:0] hit_count;
   logic [31:0] lookup_count;

   modport source (output valid, output hit, output evicted, output evicted_tag,
                   output evicted_dirty, output hit_count, output lookup_count,
                   input ready);
   modport sink   (input valid, input hit, input evicted, input evicted_tag,
                   input evicted_dirty, input hit_count, input lookup_count,
                   output ready);
endinterface

FILE: sv/sacl_tag_ram.sv
// Tag memory: one row per set, one write port and one registered read port.
module sacl_tag_ram #(
   parameter int SETS  = sacl_pkg::DEFAULT_SETS,
   parameter int ROW_W = sacl_pkg::DEFAULT_WAYS * sacl_pkg::WAY_BITS,
   localparam int ADDR_W = (SETS > 1) ? $clog2(SETS) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  logic [ROW_W-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_W-1:0]     rd_addr,
   output logic [ROW_W-1:0]      rd_data
);
   logic [ROW_W-1:0] mem_ff [SETS];
   logic [ROW_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/sacl_way_logic.sv
// Hit detection, victim choice and age/dirty update for one set row.
module sacl_way_logic #(
   parameter int WAYS = sacl_pkg::DEFAULT_WAYS,
   localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1
) (
   input  sacl_pkg::way_type [WAYS-1:0]     row_in,
   input  logic [sacl_pkg::TAG_W-1:0]       tag,
   input  logic [1:0]                       opcode,
   input  logic                             write_alloc,
   input  logic                             repl_mode,
   input  logic [WAY_W-1:0]                 rand_way,
   output sacl_pkg::way_type [WAYS-1:0]     row_out,
   output sacl_pkg::lookup_result_type      result
);
   logic                        hit;
   logic [WAY_W-1:0]            hit_way;
   logic                        found_free;
   logic [WAY_W-1:0]            free_way;
   logic [WAY_W-1:0]            lru_way;
   logic [sacl_pkg::AGE_W-1:0]  best_age;
   logic [WAY_W-1:0]            victim;
   logic [WAY_W-1:0]            used_way;
   logic                        allocate;
   logic                        evict;

   always_comb begin
      hit = 1'b0;
      hit_way = '0;
      found_free = 1'b0;
      free_way = '0;
      // Scanning downward leaves the lowest matching way.
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (row_in[w].valid && (row_in[w].tag == tag)) begin
            hit = 1'b1;
            hit_way = WAY_W'(w);
         end
         if (!row_in[w].valid) begin
            found_free = 1'b1;
            free_way = WAY_W'(w);
         end
      end

      best_age = row_in[0].age;
      lru_way = '0;
      for (int w = 1; w < WAYS; w++) begin
         if (row_in[w].age > best_age) begin
            best_age = row_in[w].age;
            lru_way = WAY_W'(w);
         end
      end

      allocate = !((opcode == sacl_pkg::OP_LOOKUP) ||
                   ((opcode == sacl_pkg::OP_DATA_WRITE) && !write_alloc));

      if (found_free) begin
         victim = free_way;
      end else if (repl_mode == sacl_pkg::REPL_RANDOM) begin
         victim = rand_way;
      end else begin
         victim = lru_way;
      end

      evict = !hit && allocate && !found_free;
      used_way = hit ? hit_way : victim;

      row_out = row_in;
      if (hit && (opcode == sacl_pkg::OP_DATA_WRITE)) begin
         row_out[hit_way].dirty = 1'b1;
      end
      if (!hit && allocate) begin
         row_out[victim].valid = 1'b1;
         row_out[victim].dirty = 1'b0;
         row_out[victim].tag   = tag;
      end
      if (hit || allocate) begin
         for (int w = 0; w < WAYS; w++) begin
            if (WAY_W'(w) == used_way) begin
               row_out[w].age = '0;
            end else if (row_in[w].age != sacl_pkg::AGE_MAX) begin
               row_out[w].age = row_in[w].age + 1'b1;
            end
         end
      end

      result.hit           = hit;
      result.evicted       = evict;
      result.evicted_tag   = evict ? row_in[victim].tag : '0;
      result.evicted_dirty = evict ? row_in[victim].dirty : 1'b0;
      result.lfsr_step     = evict && (repl_mode == sacl_pkg::REPL_RANDOM);
   end

endmodule

FILE: sv/set_assoc_cache_tag_lookup_unit.sv
// Set-associative cache tag lookup unit: control, configuration and counters.
//
// Requests arrive on req_bus (opcode, address); each one yields exactly one
// beat on rsp_bus with hit, eviction details and the running hit and access
// totals. A request beat is taken in ST_IDLE, the set row is read from the
// tag memory at that edge, and in ST_LOOK the row is updated, written back
// and the response is loaded into the output register once it is free. A new
// request is taken only after the last one has written its row back, since
// each is a read-modify-write of one memory row. The response register
// sits between the two channels: a new request is taken while an earlier
// response still waits. If the receiver stalls and a finished lookup has no
// free response register, the update waits in place and nothing is lost.
// After reset the unit clears the tag memory one set per cycle, through all
// SETS sets, with req_bus.ready low; configuration writes on the csr_ port are
// taken at any time, but belong between requests, while none is in flight.
module set_assoc_cache_tag_lookup_unit #(
   parameter int WAYS = sacl_pkg::DEFAULT_WAYS,
   parameter int SETS = sacl_pkg::DEFAULT_SETS
) (
   input  logic                              clock,
   input  logic                              reset,
   sacl_req_if.sink                          req_bus,
   sacl_rsp_if.source                        rsp_bus,
   input  logic                              csr_we,
   input  logic [sacl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sacl_pkg::CSR_W-1:0]        csr_wdata
);
   localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int ROW_W = WAYS * sacl_pkg::WAY_BITS;
   localparam int RECIP_SHIFT = 20;
   localparam logic [RECIP_SHIFT:0] RECIP =
      (RECIP_SHIFT+1)'(((2 ** RECIP_SHIFT) + WAYS - 1) / WAYS);

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_LOOK  = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [SET_W-1:0] clr_cnt_ff, clr_cnt_in;

   logic [4:0] offset_bits_ff;
   logic [2:0] set_bits_ff;
   logic       write_alloc_ff;
   logic       repl_mode_ff;

   logic [SET_W-1:0]           set_ff;
   logic [sacl_pkg::TAG_W-1:0] tag_ff;
   logic [1:0]                 op_ff;

   logic [sacl_pkg::LFSR_W-1:0] lfsr_ff;
   logic [sacl_pkg::LFSR_W-1:0] lfsr_nx;
   logic [sacl_pkg::LFSR_W-1:0] quot_ff;
   logic [sacl_pkg::LFSR_W+RECIP_SHIFT:0] quot_prod;
   logic [sacl_pkg::LFSR_W-1:0] rand_rem;
   logic [WAY_W-1:0]            rand_way;

   logic [31:0] hit_total_ff;
   logic [31:0] lookup_total_ff;

   logic        rsp_valid_ff;
   logic        rsp_hit_ff;
   logic        rsp_evicted_ff;
   logic [31:0] rsp_evicted_tag_ff;
   logic        rsp_evicted_dirty_ff;

   logic                 req_fire;
   logic                 look_done;
   logic [31:0]          shifted;
   logic [6:0]           set_mask;
   logic [SET_W-1:0]     req_set;
   logic [5:0]           tag_shift;
   logic [sacl_pkg::TAG_W-1:0] req_tag;

   logic                 ram_wr_en;
   logic [SET_W-1:0]     ram_wr_addr;
   logic [ROW_W-1:0]     ram_wr_data;
   logic [ROW_W-1:0]     ram_rd_data;

   sacl_pkg::way_type [WAYS-1:0]  row_rd;
   sacl_pkg::way_type [WAYS-1:0]  row_wr;
   sacl_pkg::lookup_result_type   result;

   // Reduces a masked set index below SETS by conditional subtraction.
   function automatic logic [SET_W-1:0] reduce_set(input logic [6:0] v);
      logic [6:0] r;
      r = v;
      for (int k = 6; k >= 0; k--) begin
         if ((SETS << k) <= 127) begin
            if ({25'd0, r} >= (SETS << k)) begin
               r = r - 7'(SETS << k);
            end
         end
      end
      return SET_W'(r);
   endfunction

   assign req_fire  = req_bus.valid && req_bus.ready;
   assign look_done = (state_ff == ST_LOOK) && (!rsp_valid_ff || rsp_bus.ready);

   // Address split.
   assign shifted   = req_bus.address >> offset_bits_ff;
   assign set_mask  = ~(7'h7F << set_bits_ff);
   assign req_set   = reduce_set(shifted[6:0] & set_mask);
   assign tag_shift = {1'b0, offset_bits_ff} + {3'b000, set_bits_ff};
   assign req_tag   = (tag_shift >= 6'd32) ? '0 : (req_bus.address >> tag_shift);

   // The modulo of the next LFSR value uses a reciprocal; the quotient is
   // registered ahead, since the LFSR only moves when a lookup completes.
   assign lfsr_nx   = sacl_pkg::lfsr_next(lfsr_ff);
   assign quot_prod = {{(RECIP_SHIFT+1){1'b0}}, lfsr_nx} *
                      {{sacl_pkg::LFSR_W{1'b0}}, RECIP};
   assign rand_rem  = lfsr_nx - sacl_pkg::LFSR_W'(quot_ff * WAYS);
   assign rand_way  = WAY_W'(rand_rem);

   always_ff @(posedge clock) begin
      quot_ff <= quot_prod[sacl_pkg::LFSR_W+RECIP_SHIFT-1:RECIP_SHIFT];
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      clr_cnt_in = clr_cnt_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == SET_W'(SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (look_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   assign req_bus.ready = (state_ff == ST_IDLE);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_bits_ff <= 5'd4;
         set_bits_ff    <= 3'd6;
         write_alloc_ff <= 1'b0;
         repl_mode_ff   <= sacl_pkg::REPL_LRU;
      end else if (csr_we) begin
         unique case (csr_index)
            sacl_pkg::CSR_OFFSET_BITS: offset_bits_ff <= csr_wdata;
            sacl_pkg::CSR_SET_BITS:    set_bits_ff    <= csr_wdata[2:0];
            sacl_pkg::CSR_WRITE_ALLOC: write_alloc_ff <= csr_wdata[0];
            sacl_pkg::CSR_REPL_MODE:   repl_mode_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         set_ff <= req_set;
         tag_ff <= req_tag;
         op_ff  <= req_bus.opcode;
      end
   end

   // Tag memory access: clearing pass, then one write-back per lookup.
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = set_ff;
      ram_wr_data = row_wr;
      if (state_ff == ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_cnt_ff;
         ram_wr_data = '0;
      end else if (look_done) begin
         ram_wr_en = 1'b1;
      end
   end

   sacl_tag_ram #(
      .SETS  (SETS),
      .ROW_W (ROW_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (req_fire),
      .rd_addr (req_set),
      .rd_data (ram_rd_data)
   );

   assign row_rd = ram_rd_data;

   sacl_way_logic #(
      .WAYS (WAYS)
   ) u_way (
      .row_in      (row_rd),
      .tag         (tag_ff),
      .opcode      (op_ff),
      .write_alloc (write_alloc_ff),
      .repl_mode   (repl_mode_ff),
      .rand_way    (rand_way),
      .row_out     (row_wr),
      .result      (result)
   );

   // LFSR, totals and response valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff         <= sacl_pkg::LFSR_SEED;
         hit_total_ff    <= '0;
         lookup_total_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (look_done) begin
            if (result.lfsr_step) begin
               lfsr_ff <= lfsr_nx;
            end
            hit_total_ff    <= hit_total_ff + {31'd0, result.hit};
            lookup_total_ff <= lookup_total_ff + 32'd1;
         end
         priority if (look_done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= rsp_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (look_done) begin
         rsp_hit_ff           <= result.hit;
         rsp_evicted_ff       <= result.evicted;
         rsp_evicted_tag_ff   <= result.evicted_tag;
         rsp_evicted_dirty_ff <= result.evicted_dirty;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.hit           = rsp_hit_ff;
   assign rsp_bus.evicted       = rsp_evicted_ff;
   assign rsp_bus.evicted_tag   = rsp_evicted_tag_ff;
   assign rsp_bus.evicted_dirty = rsp_evicted_dirty_ff;
   assign rsp_bus.hit_count     = hit_total_ff;
   assign rsp_bus.lookup_count  = lookup_total_ff;

endmodule

FILE: sv/sacl_checker.sv
// Port-level assertions for the cache tag lookup unit, with their bind.
module sacl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_hit,
   input logic        rsp_evicted,
   input logic [31:0] rsp_evicted_tag,
   input logic        rsp_evicted_dirty
);

   // A pending response beat stays offered until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // Only a miss can evict a line.
   a_evict_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted |-> !rsp_hit)
      else $error("eviction reported on a hit");

   // Eviction fields read zero when nothing was evicted.
   a_evict_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evicted |-> (rsp_evicted_tag == 32'd0) && !rsp_evicted_dirty)
      else $error("eviction fields nonzero without eviction");

   // No new request is taken in the cycle after one is taken, while its set row is updated.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken during a row update");

   // No response is offered right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response offered after reset");

endmodule

bind set_assoc_cache_tag_lookup_unit sacl_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_hit           (rsp_bus.hit),
   .rsp_evicted       (rsp_bus.evicted),
   .rsp_evicted_tag   (rsp_bus.evicted_tag),
   .rsp_evicted_dirty (rsp_bus.evicted_dirty)
);

FILE: tb/sv/sacl_lookup_checker.sv
// Checker of the cache tag lookup unit: watches both channels, predicts and compares results.
module sacl_lookup_checker #(
   parameter int WAYS = sacl_pkg::DEFAULT_WAYS,
   parameter int SETS = sacl_pkg::DEFAULT_SETS
) (
   input  logic                           clock,
   input  logic                           reset,
   sacl_req_if                            req_mon,
   sacl_rsp_if                            rsp_mon,
   input  logic                           csr_we,
   input  logic [sacl_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sacl_pkg::CSR_W-1:0]     csr_wdata,
   output int                             mismatch_count,
   output int                             outstanding
);
   import sacl_pkg::*;

   localparam int LINES = SETS * WAYS;

   typedef struct packed {
      logic             hit;
      logic             evicted;
      logic [TAG_W-1:0] evicted_tag;
      logic             evicted_dirty;
      logic [31:0]      hit_count;
      logic [31:0]      lookup_count;
   } lookup_rsp_type;

   // Shadow copy of the tag memory, indexed by set * WAYS + way.
   logic [TAG_W-1:0]  line_tag   [LINES];
   logic              line_valid [LINES];
   logic              line_dirty [LINES];
   logic [AGE_W-1:0]  line_age   [LINES];
   logic [LFSR_W-1:0] victim_lfsr;
   logic [31:0]       hits_so_far;
   logic [31:0]       lookups_so_far;

   logic [4:0] cfg_offset_bits;
   logic [2:0] cfg_set_bits;
   logic       cfg_write_alloc;
   logic       cfg_repl_mode;

   lookup_rsp_type pending_rsps[$];
   int             failures = 0;

   // The used way becomes the youngest; every other way of the set ages, saturating.
   function automatic void age_set(int unsigned base, int unsigned used);
      int unsigned w;
      for (w = 0; w < WAYS; w++) begin
         if (w == used)
            line_age[base + w] = '0;
         else if (line_age[base + w] != AGE_MAX)
            line_age[base + w] = line_age[base + w] + 1'b1;
      end
   endfunction

   task automatic predict_lookup(input logic [1:0] op, input logic [31:0] addr,
                                 output lookup_rsp_type rsp);
      logic [31:0]      shifted;
      logic [31:0]      set_mask;
      logic [TAG_W-1:0] tag;
      logic [AGE_W-1:0] oldest;
      int unsigned      set_idx, base, way, w, tag_shift;
      bit               found, may_fill, free_way;

      shifted   = addr >> cfg_offset_bits;
      set_mask  = (32'd1 << cfg_set_bits) - 32'd1;
      set_idx   = (shifted & set_mask) % SETS;
      tag_shift = cfg_offset_bits + cfg_set_bits;
      tag       = (tag_shift < 32) ? (addr >> tag_shift) : '0;
      base      = set_idx * WAYS;
      may_fill  = !(op == OP_LOOKUP || (op == OP_DATA_WRITE && !cfg_write_alloc));
      rsp       = '0;
      found     = 1'b0;
      way       = 0;

      for (w = 0; w < WAYS; w++) begin
         if (!found && line_valid[base + w] && line_tag[base + w] == tag) begin
            found = 1'b1;
            way   = w;
         end
      end

      if (found) begin
         if (op == OP_DATA_WRITE)
            line_dirty[base + way] = 1'b1;
         age_set(base, way);
      end else if (may_fill) begin
         free_way = 1'b0;
         for (w = 0; w < WAYS; w++) begin
            if (!free_way && !line_valid[base + w]) begin
               free_way = 1'b1;
               way      = w;
            end
         end
         if (!free_way) begin
            if (cfg_repl_mode == REPL_RANDOM) begin
               victim_lfsr = {victim_lfsr[0] ^ victim_lfsr[2] ^ victim_lfsr[3] ^ victim_lfsr[5],
                              victim_lfsr[LFSR_W-1:1]};
               way = victim_lfsr % WAYS;
            end else begin
               // Oldest line wins; a tie keeps the lower way.
               oldest = line_age[base];
               way    = 0;
               for (w = 1; w < WAYS; w++) begin
                  if (line_age[base + w] > oldest) begin
                     oldest = line_age[base + w];
                     way    = w;
                  end
               end
            end
            rsp.evicted       = 1'b1;
            rsp.evicted_tag   = line_tag[base + way];
            rsp.evicted_dirty = line_dirty[base + way];
         end
         line_tag[base + way]   = tag;
         line_valid[base + way] = 1'b1;
         line_dirty[base + way] = 1'b0;
         age_set(base, way);
      end

      lookups_so_far = lookups_so_far + 1;
      if (found)
         hits_so_far = hits_so_far + 1;
      rsp.hit          = found;
      rsp.hit_count    = hits_so_far;
      rsp.lookup_count = lookups_so_far;
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s: expected 0x%08h, got 0x%08h", name, exp_val, act_val);
         failures++;
      end
   endtask

   always @(posedge clock) begin : monitor
      lookup_rsp_type predicted;
      lookup_rsp_type oldest_exp;
      int             i;

      if (reset) begin
         for (i = 0; i < LINES; i++) begin
            line_tag[i]   = '0;
            line_valid[i] = 1'b0;
            line_dirty[i] = 1'b0;
            line_age[i]   = '0;
         end
         victim_lfsr     = LFSR_SEED;
         hits_so_far     = '0;
         lookups_so_far  = '0;
         cfg_offset_bits = 5'd4;
         cfg_set_bits    = 3'd6;
         cfg_write_alloc = 1'b0;
         cfg_repl_mode   = REPL_LRU;
         pending_rsps.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_OFFSET_BITS: cfg_offset_bits = csr_wdata;
               CSR_SET_BITS:    cfg_set_bits    = csr_wdata[2:0];
               CSR_WRITE_ALLOC: cfg_write_alloc = csr_wdata[0];
               CSR_REPL_MODE:   cfg_repl_mode   = csr_wdata[0];
               default: ;
            endcase
         end

         // A response beat can never belong to the request beat of the same edge.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_rsps.size() == 0) begin
               $error("response beat with no lookup outstanding");
               failures++;
            end else begin
               oldest_exp = pending_rsps.pop_front();
               check_field("hit", oldest_exp.hit, rsp_mon.hit);
               check_field("evicted", oldest_exp.evicted, rsp_mon.evicted);
               check_field("evicted_tag", oldest_exp.evicted_tag, rsp_mon.evicted_tag);
               check_field("evicted_dirty", oldest_exp.evicted_dirty, rsp_mon.evicted_dirty);
               check_field("hit_count", oldest_exp.hit_count, rsp_mon.hit_count);
               check_field("lookup_count", oldest_exp.lookup_count, rsp_mon.lookup_count);
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            predict_lookup(req_mon.opcode, req_mon.address, predicted);
            pending_rsps = {pending_rsps, predicted};
         end
      end

      outstanding    <= pending_rsps.size();
      mismatch_count <= failures;
   end

endmodule

FILE: tb/sv/set_assoc_cache_tag_lookup_unit_test.sv
// Top of the cache tag lookup unit testbench: clock, reset, stimulus and verdict.
module set_assoc_cache_tag_lookup_unit_test;
   import sacl_pkg::*;

   localparam int WAYS        = DEFAULT_WAYS;
   localparam int SETS        = DEFAULT_SETS;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PLANS       = 8;
   localparam int PLAN_ITEMS  = 212;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   sacl_req_if req_bus ();
   sacl_rsp_if rsp_bus ();

   int mismatch_count;
   int outstanding;
   int cycle_count = 0;
   int sender_idle_pct;
   int receiver_stall_pct;

   logic [31:0] recent_addrs[$];
   logic [4:0]  cur_offset_bits;
   logic [2:0]  cur_set_bits;

   set_assoc_cache_tag_lookup_unit #(
      .WAYS (WAYS),
      .SETS (SETS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sacl_lookup_checker #(
      .WAYS (WAYS),
      .SETS (SETS)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      sender_idle_pct    = sender_pct;
      receiver_stall_pct <= receiver_pct;
   endtask

   // Drops valid and holds off until every predicted response beat has been taken.
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_cache(input logic [4:0] ob, input logic [2:0] sb,
                                input logic wa, input logic rm);
      settle();
      csr_we    <= 1'b1;
      csr_index <= CSR_OFFSET_BITS;
      csr_wdata <= ob;
      @(posedge clock);
      csr_index <= CSR_SET_BITS;
      csr_wdata <= CSR_W'(sb);
      @(posedge clock);
      csr_index <= CSR_WRITE_ALLOC;
      csr_wdata <= CSR_W'(wa);
      @(posedge clock);
      csr_index <= CSR_REPL_MODE;
      csr_wdata <= CSR_W'(rm);
      @(posedge clock);
      csr_we <= 1'b0;
      cur_offset_bits = ob;
      cur_set_bits    = sb;
   endtask

   // Leaves valid high on return so that back-to-back beats need no second assignment.
   task automatic send_access(input logic [1:0] op, input logic [31:0] addr);
      int gap;
      if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         gap = $urandom_range(4, 1);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.opcode  <= op;
      req_bus.address <= addr;
      do
         @(posedge clock);
      while (req_bus.ready !== 1'b1);
      recent_addrs = {recent_addrs, addr};
      if (recent_addrs.size() > 48)
         void'(recent_addrs.pop_front());
   endtask

   // Reused lines half the time and a few crowded sets most of the rest, so hits and evictions are common.
   function automatic logic [31:0] pick_address();
      int          r;
      int          tag_shift;
      logic [31:0] a;
      r = $urandom_range(99);
      if (r < 50 && recent_addrs.size() != 0) begin
         a = recent_addrs[$urandom_range(recent_addrs.size() - 1)];
         if ($urandom_range(1) == 1)
            a = a ^ ($urandom & ((32'd1 << cur_offset_bits) - 32'd1));
      end else if (r < 85) begin
         tag_shift = cur_offset_bits + cur_set_bits;
         a = $urandom & ((32'd1 << cur_offset_bits) - 32'd1);
         a = a | (32'($urandom_range(3)) << cur_offset_bits);
         if (tag_shift < 32)
            a = a | (32'($urandom_range(7)) << tag_shift);
      end else begin
         a = $urandom;
      end
      return a;
   endfunction

   task automatic program_plan(input int idx);
      case (idx)
         0: program_cache(5'd4, 3'd6, 1'b0, REPL_LRU);
         1: program_cache(5'd4, 3'd6, 1'b1, REPL_RANDOM);
         2: program_cache(5'd0, 3'd0, 1'b1, REPL_LRU);
         3: program_cache(5'd31, 3'd7, 1'b0, REPL_RANDOM);
         4: program_cache(5'd6, 3'd2, 1'b1, REPL_LRU);
         5: program_cache(5'd16, 3'd6, 1'b0, REPL_RANDOM);
         6: program_cache(5'd2, 3'd7, 1'b1, REPL_RANDOM);
         default: program_cache(5'd12, 3'd4, 1'b1, REPL_LRU);
      endcase
   endtask

   initial begin : stimulus
      int          k;
      int          n;
      logic [1:0]  op;
      logic [31:0] addr;

      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = CSR_OFFSET_BITS;
      csr_wdata       = '0;
      req_bus.valid   = 1'b0;
      req_bus.opcode  = OP_DATA_READ;
      req_bus.address = '0;
      cur_offset_bits = 5'd4;
      cur_set_bits    = 3'd6;
      set_idling(0, 0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: set 0 is filled through every opcode, then a dirty line is aged out.
      program_cache(5'd4, 3'd6, 1'b0, REPL_LRU);
      send_access(OP_DATA_READ, 32'h0000_0000);
      send_access(OP_DATA_READ, 32'h0000_0004);
      send_access(OP_DATA_WRITE, 32'h0000_0000);
      send_access(OP_DATA_WRITE, 32'h0000_0400);
      send_access(OP_LOOKUP, 32'h0000_0400);
      send_access(OP_INST_READ, 32'h0000_0400);
      send_access(OP_LOOKUP, 32'h0000_0400);
      send_access(OP_DATA_READ, 32'h0000_0800);
      send_access(OP_INST_READ, 32'h0000_0C00);
      send_access(OP_DATA_READ, 32'h0000_1000);
      send_access(OP_DATA_READ, 32'hFFFF_FFFF);
      send_access(OP_DATA_WRITE, 32'hFFFF_FFFF);

      // Write misses now allocate, and victims come from the random sequence.
      program_cache(5'd4, 3'd6, 1'b1, REPL_RANDOM);
      send_access(OP_DATA_WRITE, 32'h0000_2000);
      send_access(OP_DATA_WRITE, 32'h0000_2400);
      send_access(OP_DATA_READ, 32'h0000_2000);

      // Offset and set fields reaching past bit 31 leave a zero tag.
      program_cache(5'd31, 3'd7, 1'b1, REPL_RANDOM);
      send_access(OP_DATA_READ, 32'h8000_0000);
      send_access(OP_DATA_WRITE, 32'h0000_0000);

      // No offset and no set bits: the whole address is the tag.
      program_cache(5'd0, 3'd0, 1'b0, REPL_LRU);
      send_access(OP_DATA_READ, 32'h1234_5678);
      send_access(OP_DATA_WRITE, 32'h1234_5678);

      // A seven-bit set index wraps back into the table.
      program_cache(5'd2, 3'd7, 1'b0, REPL_LRU);
      send_access(OP_DATA_READ, 32'h0000_01FC);
      send_access(OP_LOOKUP, 32'hFFFF_FFFF);

      for (k = 0; k < PLANS; k++) begin
         program_plan(k);
         case (k % 4)
            0: set_idling(0, 0);
            1: set_idling(77, 0);
            2: set_idling(0, 77);
            default: set_idling(24, 24);
         endcase
         for (n = 0; n < PLAN_ITEMS; n++) begin
            if (n == PLAN_ITEMS / 2)
               settle();
            op   = 2'($urandom_range(3));
            addr = pick_address();
            send_access(op, addr);
         end
      end

      settle();
      repeat (6) @(posedge clock);
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
